// ----- hdl/qlh_pkg.sv -----
// ----------------------------------------------------------------------------
// qlh_pkg
// Shared types and constants of the queue latency log2 histogram.
// ----------------------------------------------------------------------------
package qlh_pkg;

    localparam int PENDING_DEPTH = 1024;
    localparam int PEND_AW       = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int ROW_DEPTH     = 1024;
    localparam int ROW_AW        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int BIN_COUNT     = 32;
    localparam int BIN_AW        = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int BIN_ADDR_W    = ROW_AW + BIN_AW;
    localparam int BIN_DEPTH     = ROW_DEPTH * BIN_COUNT;
    localparam int CLR_DEPTH     = (PENDING_DEPTH > ROW_DEPTH) ? PENDING_DEPTH : ROW_DEPTH;
    localparam int CLR_AW        = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 104;

    localparam logic [63:0] INIT_TAG  = 64'h494E_4954_5F57_515F;
    localparam logic [63:0] NS_PER_US = 64'd1000;

    typedef enum logic [1:0] {
        CMD_QUEUE,
        CMD_START,
        CMD_READ,
        CMD_NONE
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK,
        STS_PEND_FULL,
        STS_NO_PEND,
        STS_FILTERED,
        STS_ROWS_FULL
    } status_t;

    typedef enum logic [1:0] {
        CFG_NS_UNITS,
        CFG_PER_QUEUE,
        CFG_FILT_EN,
        CFG_FILT_TAG
    } cfg_idx_t;

    typedef enum logic [3:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_PSCAN,
        FSM_LOG,
        FSM_RSCAN,
        FSM_BCLR,
        FSM_BRD,
        FSM_BWR,
        FSM_RDWAIT,
        FSM_OUT
    } fsm_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_SCAN
    } lg_state_t;

    typedef struct packed {
        logic        start;
        logic        ns_units;
        logic [63:0] delta;
    } lg_req_t;

    typedef struct packed {
        logic              done;
        logic [BIN_AW-1:0] bin;
    } lg_rsp_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] tag;
        logic [63:0] ts;
        logic [63:0] id;
    } pend_entry_t;

    typedef struct packed {
        logic        used;
        logic [63:0] key;
    } row_entry_t;

endpackage

// ----- hdl/queue_latency_log2_histogram.sv -----
// ----------------------------------------------------------------------------
// queue_latency_log2_histogram
// Pairs queue and start events per thread and counts their latency in log2
// histograms (per queue tag or one shared row) held in on-chip memories.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Contents
//  --------+----------------------------+-----------------------------------
//  input   | s_tvalid/s_tready/s_tdata  | event or read command, cmd in tuser
//  result  | m_tvalid/m_tready/m_tdata  | one result per command, status in tuser
//  config  | cfg_valid/cfg_ready        | register index and 64-bit data
//
//  After reset a clearing pass empties the pending and row tables; no
//  command is taken meanwhile. A queue event scans the pending memory
//  linearly, one entry per cycle. A start event adds up to 32 threshold
//  compares for the log2 bin, a scan of the row memory, the clearing of
//  the counters of a new row and a counter read-modify-write. A held result
//  stalls the next one only.
// ----------------------------------------------------------------------------
module queue_latency_log2_histogram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // thread_id, timestamp_ns, queue_tag, read_row, read_bin, zero pad
    input  logic [qlh_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // row_valid, row_tag, bin_count, bin_hit, zero pad
    output logic [qlh_pkg::M_TDATA_W-1:0] m_tdata,
    // status
    output logic [2:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [63:0]                   cfg_data
);
    import qlh_pkg::*;

    fsm_t state_reg, state_next;

    logic        ns_units_reg, per_queue_reg, filt_en_reg;
    logic [63:0] filt_tag_reg;

    cmd_t        cmd_reg, cmd_next;
    logic [63:0] id_reg, id_next;
    logic [63:0] ts_reg, ts_next;
    logic [63:0] tag_reg, tag_next;
    logic [63:0] key_reg, key_next;
    logic        oob_reg, oob_next;
    logic [BIN_AW-1:0] bin_reg, bin_next;
    logic [ROW_AW-1:0] row_reg, row_next;

    logic [CLR_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [BIN_AW-1:0] bclr_cnt_reg, bclr_cnt_next;

    // scan of the pending table
    logic [PEND_AW:0]   p_cnt_reg, p_cnt_next;
    logic               p_chk_reg, p_chk_next;
    logic [PEND_AW-1:0] p_idx_reg, p_idx_next;
    logic               p_free_reg, p_free_next;
    logic [PEND_AW-1:0] p_fidx_reg, p_fidx_next;
    // scan of the row table
    logic [ROW_AW:0]    r_cnt_reg, r_cnt_next;
    logic               r_chk_reg, r_chk_next;
    logic [ROW_AW-1:0]  r_idx_reg, r_idx_next;
    logic               r_free_reg, r_free_next;
    logic [ROW_AW-1:0]  r_fidx_reg, r_fidx_next;

    status_t     res_sts_reg, res_sts_next;
    logic        res_vld_reg, res_vld_next;
    logic [63:0] res_tag_reg, res_tag_next;
    logic [31:0] res_cnt_reg, res_cnt_next;
    logic [4:0]  res_hit_reg, res_hit_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]           m_user_reg, m_user_next;

    logic               p_we;
    logic [PEND_AW-1:0] p_waddr, p_raddr;
    pend_entry_t        p_wdata, p_rdata;
    logic               r_we;
    logic [ROW_AW-1:0]  r_waddr, r_raddr;
    row_entry_t         r_wdata, r_rdata;
    logic                  b_we;
    logic [BIN_ADDR_W-1:0] b_waddr, b_raddr;
    logic [31:0]           b_wdata, b_rdata;

    lg_req_t lg_req;
    lg_rsp_t lg_rsp;

    logic [9:0] in_row;
    logic [4:0] in_bin;

    assign in_row = s_tdata[201:192];
    assign in_bin = s_tdata[206:202];

    qlh_ram #(.WIDTH($bits(pend_entry_t)), .DEPTH(PENDING_DEPTH), .AW(PEND_AW)) u_pend_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    qlh_ram #(.WIDTH($bits(row_entry_t)), .DEPTH(ROW_DEPTH), .AW(ROW_AW)) u_row_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    qlh_ram #(.WIDTH(32), .DEPTH(BIN_DEPTH), .AW(BIN_ADDR_W)) u_bin_ram (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    qlh_div_log2 u_div_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lg_req),
        .rsp     (lg_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ns_units_reg  <= 1'b0;
            per_queue_reg <= 1'b0;
            filt_en_reg   <= 1'b0;
            filt_tag_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_NS_UNITS:  ns_units_reg  <= cfg_data[0];
                CFG_PER_QUEUE: per_queue_reg <= cfg_data[0];
                CFG_FILT_EN:   filt_en_reg   <= cfg_data[0];
                CFG_FILT_TAG:  filt_tag_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            p_chk_reg   <= 1'b0;
            r_chk_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
            p_chk_reg   <= p_chk_next;
            r_chk_reg   <= r_chk_next;
        end
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        ts_reg       <= ts_next;
        tag_reg      <= tag_next;
        key_reg      <= key_next;
        oob_reg      <= oob_next;
        bin_reg      <= bin_next;
        row_reg      <= row_next;
        bclr_cnt_reg <= bclr_cnt_next;
        p_cnt_reg    <= p_cnt_next;
        p_idx_reg    <= p_idx_next;
        p_free_reg   <= p_free_next;
        p_fidx_reg   <= p_fidx_next;
        r_cnt_reg    <= r_cnt_next;
        r_idx_reg    <= r_idx_next;
        r_free_reg   <= r_free_next;
        r_fidx_reg   <= r_fidx_next;
        res_sts_reg  <= res_sts_next;
        res_vld_reg  <= res_vld_next;
        res_tag_reg  <= res_tag_next;
        res_cnt_reg  <= res_cnt_next;
        res_hit_reg  <= res_hit_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        ts_next       = ts_reg;
        tag_next      = tag_reg;
        key_next      = key_reg;
        oob_next      = oob_reg;
        bin_next      = bin_reg;
        row_next      = row_reg;
        bclr_cnt_next = bclr_cnt_reg;
        p_cnt_next    = p_cnt_reg;
        p_chk_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        p_free_next   = p_free_reg;
        p_fidx_next   = p_fidx_reg;
        r_cnt_next    = r_cnt_reg;
        r_chk_next    = 1'b0;
        r_idx_next    = r_idx_reg;
        r_free_next   = r_free_reg;
        r_fidx_next   = r_fidx_reg;
        res_sts_next  = res_sts_reg;
        res_vld_next  = res_vld_reg;
        res_tag_next  = res_tag_reg;
        res_cnt_next  = res_cnt_reg;
        res_hit_next  = res_hit_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        s_tready      = 1'b0;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_raddr = p_cnt_reg[PEND_AW-1:0];
        r_we    = 1'b0;
        r_waddr = '0;
        r_wdata = '0;
        r_raddr = r_cnt_reg[ROW_AW-1:0];
        b_we    = 1'b0;
        b_waddr = {row_reg, bin_reg};
        b_wdata = '0;
        b_raddr = {row_reg, bin_reg};
        lg_req  = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_CLEAR: begin
                if (32'(clr_cnt_reg) < PENDING_DEPTH) begin
                    p_we    = 1'b1;
                    p_waddr = PEND_AW'(clr_cnt_reg);
                end
                if (32'(clr_cnt_reg) < ROW_DEPTH) begin
                    r_we    = 1'b1;
                    r_waddr = ROW_AW'(clr_cnt_reg);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == CLR_DEPTH - 1) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                r_raddr  = ROW_AW'(in_row);
                b_raddr  = {ROW_AW'(in_row), BIN_AW'(in_bin)};
                if (s_tvalid) begin
                    cmd_next     = cmd_t'(s_tuser);
                    id_next      = s_tdata[63:0];
                    ts_next      = s_tdata[127:64];
                    tag_next     = s_tdata[191:128];
                    oob_next     = (32'(in_row) >= ROW_DEPTH) || (32'(in_bin) >= BIN_COUNT);
                    res_sts_next = STS_OK;
                    res_vld_next = 1'b0;
                    res_tag_next = '0;
                    res_cnt_next = '0;
                    res_hit_next = '0;
                    p_cnt_next   = '0;
                    p_free_next  = 1'b0;
                    case (cmd_t'(s_tuser))
                        CMD_QUEUE, CMD_START: state_next = FSM_PSCAN;
                        CMD_READ:             state_next = FSM_RDWAIT;
                        default:              state_next = FSM_OUT;
                    endcase
                end
            end
            FSM_PSCAN: begin
                if (32'(p_cnt_reg) < PENDING_DEPTH) begin
                    p_cnt_next = p_cnt_reg + 1'b1;
                    p_chk_next = 1'b1;
                    p_idx_next = p_cnt_reg[PEND_AW-1:0];
                end
                if (p_chk_reg) begin
                    if (p_rdata.valid && p_rdata.id == id_reg) begin
                        p_chk_next = 1'b0;
                        p_we       = 1'b1;
                        p_waddr    = p_idx_reg;
                        if (cmd_reg == CMD_QUEUE) begin
                            p_wdata    = '{valid: 1'b1, tag: tag_reg, ts: ts_reg, id: id_reg};
                            state_next = FSM_OUT;
                        end else begin
                            // release the entry and time the pair
                            p_wdata        = '0;
                            tag_next       = p_rdata.tag;
                            lg_req.start   = 1'b1;
                            lg_req.ns_units = ns_units_reg;
                            lg_req.delta   = ts_reg - p_rdata.ts;
                            state_next     = FSM_LOG;
                        end
                    end else if (!p_rdata.valid && !p_free_reg) begin
                        p_free_next = 1'b1;
                        p_fidx_next = p_idx_reg;
                    end
                end else if (32'(p_cnt_reg) >= PENDING_DEPTH) begin
                    state_next = FSM_OUT;
                    if (cmd_reg == CMD_START) begin
                        res_sts_next = STS_NO_PEND;
                    end else if (p_free_reg) begin
                        p_we    = 1'b1;
                        p_waddr = p_fidx_reg;
                        p_wdata = '{valid: 1'b1, tag: tag_reg, ts: ts_reg, id: id_reg};
                    end else begin
                        res_sts_next = STS_PEND_FULL;
                    end
                end
            end
            FSM_LOG: begin
                if (lg_rsp.done) begin
                    bin_next    = lg_rsp.bin;
                    r_cnt_next  = '0;
                    r_free_next = 1'b0;
                    key_next    = (per_queue_reg || filt_en_reg) ? tag_reg : INIT_TAG;
                    if (filt_en_reg && tag_reg != filt_tag_reg) begin
                        res_sts_next = STS_FILTERED;
                        state_next   = FSM_OUT;
                    end else begin
                        state_next = FSM_RSCAN;
                    end
                end
            end
            FSM_RSCAN: begin
                if (32'(r_cnt_reg) < ROW_DEPTH) begin
                    r_cnt_next = r_cnt_reg + 1'b1;
                    r_chk_next = 1'b1;
                    r_idx_next = r_cnt_reg[ROW_AW-1:0];
                end
                if (r_chk_reg) begin
                    if (r_rdata.used && r_rdata.key == key_reg) begin
                        r_chk_next = 1'b0;
                        row_next   = r_idx_reg;
                        state_next = FSM_BRD;
                    end else if (!r_rdata.used && !r_free_reg) begin
                        r_free_next = 1'b1;
                        r_fidx_next = r_idx_reg;
                    end
                end else if (32'(r_cnt_reg) >= ROW_DEPTH) begin
                    if (r_free_reg) begin
                        r_we          = 1'b1;
                        r_waddr       = r_fidx_reg;
                        r_wdata       = '{used: 1'b1, key: key_reg};
                        row_next      = r_fidx_reg;
                        bclr_cnt_next = '0;
                        state_next    = FSM_BCLR;
                    end else begin
                        res_sts_next = STS_ROWS_FULL;
                        state_next   = FSM_OUT;
                    end
                end
            end
            FSM_BCLR: begin
                // zero the counters of a freshly taken row
                b_we          = 1'b1;
                b_waddr       = {row_reg, bclr_cnt_reg};
                bclr_cnt_next = bclr_cnt_reg + 1'b1;
                if (32'(bclr_cnt_reg) == BIN_COUNT - 1) begin
                    state_next = FSM_BRD;
                end
            end
            FSM_BRD: begin
                state_next = FSM_BWR;
            end
            FSM_BWR: begin
                b_we         = 1'b1;
                b_wdata      = b_rdata + 32'd1;
                res_hit_next = 5'(bin_reg);
                state_next   = FSM_OUT;
            end
            FSM_RDWAIT: begin
                if (r_rdata.used && !oob_reg) begin
                    res_vld_next = 1'b1;
                    res_tag_next = r_rdata.key;
                    res_cnt_next = b_rdata;
                end
                state_next = FSM_OUT;
            end
            FSM_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_hit_reg, res_cnt_reg, res_tag_reg, res_vld_reg};
                    m_user_next  = res_sts_reg;
                    state_next   = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- hdl/qlh_ram.sv -----
// ----------------------------------------------------------------------------
// qlh_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module qlh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/qlh_div_log2.sv -----
// ----------------------------------------------------------------------------
// qlh_div_log2
// Floor log2 of a latency in nanoseconds or in whole microseconds, found by
// comparing against a doubling threshold one bin per cycle, clamped to the
// last bin.
// ----------------------------------------------------------------------------
module qlh_div_log2 (
    input  logic            aclk,
    input  logic            aresetn,
    input  qlh_pkg::lg_req_t req,
    output qlh_pkg::lg_rsp_t rsp
);
    import qlh_pkg::*;

    lg_state_t         state_reg, state_next;
    logic [63:0]       val_reg, val_next;
    logic [63:0]       thr_reg, thr_next;
    logic [BIN_AW-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [BIN_AW-1:0] bin_reg, bin_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        val_reg <= val_next;
        thr_reg <= thr_next;
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
    end

    always_comb begin
        state_next = state_reg;
        val_next   = val_reg;
        thr_next   = thr_reg;
        cnt_next   = cnt_reg;
        bin_next   = bin_reg;
        done_next  = 1'b0;
        case (state_reg)
            LG_IDLE: begin
                if (req.start) begin
                    // bin k holds the latencies at or above unit * 2^k (bin 0 also those below)
                    val_next   = req.delta;
                    thr_next   = req.ns_units ? 64'd2 : (NS_PER_US << 1);
                    cnt_next   = '0;
                    state_next = LG_SCAN;
                end
            end
            LG_SCAN: begin
                if (cnt_reg != BIN_AW'(BIN_COUNT - 1) && val_reg >= thr_reg) begin
                    thr_next = thr_reg << 1;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    bin_next   = cnt_reg;
                    done_next  = 1'b1;
                    state_next = LG_IDLE;
                end
            end
            default: state_next = LG_IDLE;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.bin  = bin_reg;

endmodule
